// ----- hdl/bbcrg_pkg.sv -----
// ----------------------------------------------------------------------------
// bbcrg_pkg
// shared constants, codes and helpers for the boot-bound command replay guard
// ----------------------------------------------------------------------------
package bbcrg_pkg;

  // default configuration
  localparam int unsigned UidBytesDef     = 16;
  localparam int unsigned DigestBytesDef  = 32;
  localparam int unsigned SeqBitsDef      = 32;
  localparam int unsigned MaxErrorCodeDef = 255;

  // field widths
  localparam int unsigned IdentW   = 53;
  localparam int unsigned WordW    = 64;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned ErrW     = 16;
  localparam int unsigned UidWords = 2;
  localparam int unsigned DigWords = 4;

  typedef enum logic [1:0] {
    MODE_PROBE   = 2'd0,
    MODE_BIND    = 2'd1,
    MODE_RECEIVE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BIND_BOUND    = 2'd0,
    BIND_ALREADY  = 2'd1,
    BIND_MISMATCH = 2'd2
  } bind_status_e;

  typedef enum logic [2:0] {
    OUT_ACCEPTED = 3'd0,
    OUT_REJECTED = 3'd1,
    OUT_BOOT_MIS = 3'd2,
    OUT_CONFLICT = 3'd3,
    OUT_OLD      = 3'd4,
    OUT_NOT_SEEN = 3'd5
  } outcome_e;

  // byte mask for word w of a value that is nbytes long (elaboration only)
  function automatic logic [WordW-1:0] word_mask(int unsigned nbytes, int unsigned w);
    int n;
    logic [WordW-1:0] m;
    n = int'(nbytes) - 8 * int'(w);
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < n) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

  // identity lies in 1 .. 2^53-1
  function automatic logic ident_ok(logic [WordW-1:0] v);
    return (v != '0) && (v[WordW-1:IdentW] == '0);
  endfunction

endpackage

// ----- hdl/boot_bound_command_replay_guard_core.sv -----
// ----------------------------------------------------------------------------
// boot_bound_command_replay_guard_core
// guards a command link: probe and bind of a boot identity, then replay and
// conflict checks of commands against the latest stored command
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o | mode, ids, seq, uid, digest, app_error
//  out     | out_valid_o/out_ready_i | request_ok, status, outcome, state view
//
//  one request per cycle sustained while the result side takes each result; a
//  request passes the input register, then one compute pass into the result register
//  the guard state lives in flip-flops and is updated by the compute pass, so
//  the next request in the input register already sees it
//  rst_ni clears the guard state and all valid flags asynchronously
//  a stalled result holds the compute pass; the input register still takes a
//  request while it is empty, then in_ready_o follows the result side
//
module boot_bound_command_replay_guard_core
  import bbcrg_pkg::*;
#(
  parameter int unsigned UID_BYTES      = UidBytesDef,
  parameter int unsigned DIGEST_BYTES   = DigestBytesDef,
  parameter int unsigned SEQ_BITS       = SeqBitsDef,
  parameter int unsigned MAX_ERROR_CODE = MaxErrorCodeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [WordW-1:0]   probe_or_target_id_i,
  input  logic [WordW-1:0]   proposed_boot_i,
  input  logic [SeqW-1:0]    seq_number_i,
  input  logic [WordW-1:0]   uid_low_i,
  input  logic [WordW-1:0]   uid_high_i,
  input  logic [WordW-1:0]   digest_w0_i,
  input  logic [WordW-1:0]   digest_w1_i,
  input  logic [WordW-1:0]   digest_w2_i,
  input  logic [WordW-1:0]   digest_w3_i,
  input  logic [ErrW-1:0]    app_error_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               request_ok_o,
  output logic [1:0]         bind_status_o,
  output logic [2:0]         outcome_o,
  output logic [ErrW-1:0]    error_out_o,
  output logic [IdentW-1:0]  bound_boot_o,
  output logic [SeqW-1:0]    top_sequence_o,
  output logic               run_once_o
);

  // masks from the configured byte counts and sequence width
  localparam logic [WordW-1:0] UidMask0 = word_mask(UID_BYTES, 0);
  localparam logic [WordW-1:0] UidMask1 = word_mask(UID_BYTES, 1);
  localparam logic [WordW-1:0] DigMask0 = word_mask(DIGEST_BYTES, 0);
  localparam logic [WordW-1:0] DigMask1 = word_mask(DIGEST_BYTES, 1);
  localparam logic [WordW-1:0] DigMask2 = word_mask(DIGEST_BYTES, 2);
  localparam logic [WordW-1:0] DigMask3 = word_mask(DIGEST_BYTES, 3);
  localparam logic [SeqW-1:0]  SeqMask  = (SEQ_BITS >= SeqW) ? {SeqW{1'b1}} :
                                          SeqW'((64'd1 << SEQ_BITS) - 64'd1);
  localparam logic [ErrW-1:0]  MaxErr   = ErrW'(MAX_ERROR_CODE);

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  mode_e               s1_mode_q;
  logic [WordW-1:0]    s1_id_q;
  logic [WordW-1:0]    s1_prop_q;
  logic [SeqW-1:0]     s1_seq_q;
  logic [WordW-1:0]    s1_uid_q [UidWords];
  logic [WordW-1:0]    s1_dig_q [DigWords];
  logic [ErrW-1:0]     s1_err_q;

  logic adv;   // compute pass moves a request into the result register
  logic in_acc;

  assign adv        = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload only; seq, uid and digest masked on the way in
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q   <= mode_e'(mode_i);
      s1_id_q     <= probe_or_target_id_i;
      s1_prop_q   <= proposed_boot_i;
      s1_seq_q    <= seq_number_i & SeqMask;
      s1_uid_q[0] <= uid_low_i & UidMask0;
      s1_uid_q[1] <= uid_high_i & UidMask1;
      s1_dig_q[0] <= digest_w0_i & DigMask0;
      s1_dig_q[1] <= digest_w1_i & DigMask1;
      s1_dig_q[2] <= digest_w2_i & DigMask2;
      s1_dig_q[3] <= digest_w3_i & DigMask3;
      s1_err_q    <= app_error_i;
    end
  end

  // --------------------------------------------------------------------------
  // guard state
  // --------------------------------------------------------------------------
  logic [IdentW-1:0] boot_q,     boot_d;
  logic [IdentW-1:0] pend_q,     pend_d;
  logic [SeqW-1:0]   lseq_q,     lseq_d;
  logic [IdentW-1:0] ltgt_q,     ltgt_d;
  logic [WordW-1:0]  luid_q [UidWords];
  logic [WordW-1:0]  luid_d [UidWords];
  logic [WordW-1:0]  ldig_q [DigWords];
  logic [WordW-1:0]  ldig_d [DigWords];
  logic [ErrW-1:0]   lerr_q,     lerr_d;

  // result fields before the result register
  logic              ok_d;
  bind_status_e      bstat_d;
  outcome_e          outc_d;
  logic [ErrW-1:0]   eout_d;
  logic              run_d;

  // helper terms
  logic id_ok, prop_ok, cmd_ok, same_cmd, is_cmd;
  logic [WordW-1:0] boot_ext, pend_ext;

  always_comb begin
    boot_ext = {{(WordW-IdentW){1'b0}}, boot_q};
    pend_ext = {{(WordW-IdentW){1'b0}}, pend_q};
    id_ok    = ident_ok(s1_id_q);
    prop_ok  = ident_ok(s1_prop_q);
    is_cmd   = (s1_mode_q == MODE_RECEIVE) || (s1_mode_q == MODE_QUERY);
    cmd_ok   = id_ok && (s1_seq_q != '0) && ((s1_uid_q[0] | s1_uid_q[1]) != '0) &&
               !((s1_mode_q == MODE_RECEIVE) && (s1_err_q > MaxErr));
    // target compare is safe on the low bits: the target is a valid identity here
    same_cmd = (s1_id_q[IdentW-1:0] == ltgt_q) &&
               (s1_uid_q[0] == luid_q[0]) && (s1_uid_q[1] == luid_q[1]) &&
               (s1_dig_q[0] == ldig_q[0]) && (s1_dig_q[1] == ldig_q[1]) &&
               (s1_dig_q[2] == ldig_q[2]) && (s1_dig_q[3] == ldig_q[3]);

    boot_d = boot_q;
    pend_d = pend_q;
    lseq_d = lseq_q;
    ltgt_d = ltgt_q;
    luid_d = luid_q;
    ldig_d = ldig_q;
    lerr_d = lerr_q;

    ok_d    = 1'b0;
    bstat_d = BIND_BOUND;
    outc_d  = OUT_ACCEPTED;
    eout_d  = '0;
    run_d   = 1'b0;

    unique case (s1_mode_q)
      MODE_PROBE: begin
        if (id_ok) begin
          ok_d = 1'b1;
          if (boot_q == '0) pend_d = s1_id_q[IdentW-1:0];
        end
      end
      MODE_BIND: begin
        if (id_ok && prop_ok) begin
          ok_d = 1'b1;
          priority if (boot_q != '0) begin
            bstat_d = BIND_ALREADY;
          end else if (pend_ext != s1_id_q) begin
            bstat_d = BIND_MISMATCH;
          end else begin
            boot_d = s1_prop_q[IdentW-1:0];
            pend_d = '0;
          end
        end
      end
      default: begin
        if (is_cmd && cmd_ok) begin
          ok_d = 1'b1;
          priority if (boot_ext != s1_id_q) begin
            outc_d = OUT_BOOT_MIS;
          end else if (s1_seq_q == lseq_q) begin
            // repeat of the latest command: report what was stored
            if (same_cmd) begin
              eout_d = lerr_q;
              outc_d = (lerr_q == '0) ? OUT_ACCEPTED : OUT_REJECTED;
            end else begin
              outc_d = OUT_CONFLICT;
            end
          end else if (s1_seq_q < lseq_q) begin
            outc_d = OUT_OLD;
          end else if (s1_mode_q == MODE_RECEIVE) begin
            // new command: store it, run it once if it carries no error
            lseq_d = s1_seq_q;
            ltgt_d = s1_id_q[IdentW-1:0];
            luid_d = s1_uid_q;
            ldig_d = s1_dig_q;
            lerr_d = s1_err_q;
            eout_d = s1_err_q;
            outc_d = (s1_err_q == '0) ? OUT_ACCEPTED : OUT_REJECTED;
            run_d  = (s1_err_q == '0);
          end else begin
            outc_d = OUT_NOT_SEEN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q <= '0;
      pend_q <= '0;
      lseq_q <= '0;
      ltgt_q <= '0;
      luid_q <= '{default: '0};
      ldig_q <= '{default: '0};
      lerr_q <= '0;
    end else if (adv) begin
      boot_q <= boot_d;
      pend_q <= pend_d;
      lseq_q <= lseq_d;
      ltgt_q <= ltgt_d;
      luid_q <= luid_d;
      ldig_q <= ldig_d;
      lerr_q <= lerr_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // rejected requests report all zeros
  always_ff @(posedge clk_i) begin
    if (adv) begin
      request_ok_o   <= ok_d;
      bind_status_o  <= ok_d ? bstat_d : BIND_BOUND;
      outcome_o      <= ok_d ? outc_d : OUT_ACCEPTED;
      error_out_o    <= ok_d ? eout_d : '0;
      bound_boot_o   <= ok_d ? boot_d : '0;
      top_sequence_o <= ok_d ? lseq_d : '0;
      run_once_o     <= ok_d && run_d;
    end
  end

endmodule

// ----- bench/boot_bound_command_replay_guard_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boot_bound_command_replay_guard_core_test
// self-checking bench for the replay guard: a directed opening (probe, bind,
// invalid requests, repeats, conflicts, old and unseen commands), then random
// requests built mostly from the guard's own state, under random sender
// bursts and receiver stalls, each result checked against a local predictor
// ----------------------------------------------------------------------------
module boot_bound_command_replay_guard_core_test;
  import bbcrg_pkg::*;

  localparam logic [63:0] IdentTop    = (64'd1 << IdentW) - 64'd1;
  localparam int unsigned RandomCount = 1020;
  localparam int unsigned DrainCycles = 8;

  // one request as driven onto the input channel
  typedef struct {
    mode_e            mode;
    logic [63:0]      id;
    logic [63:0]      prop;
    logic [31:0]      seq;
    logic [1:0][63:0] uid;
    logic [3:0][63:0] dig;
    logic [15:0]      err;
  } request_t;

  // one answer as seen on the result channel
  typedef struct {
    logic              ok;
    logic [1:0]        bstat;
    logic [2:0]        outc;
    logic [15:0]       err;
    logic [IdentW-1:0] boot;
    logic [31:0]       seq;
    logic              run;
  } answer_t;

  // guard state mirror plus the queue of answers still owed by the block
  class guard_scoreboard;
    logic [IdentW-1:0] bound_id;
    logic [IdentW-1:0] pending_ident;
    logic [IdentW-1:0] stored_target;
    logic [31:0]       high_seq;
    logic [1:0][63:0]  stored_uid;
    logic [3:0][63:0]  stored_dig;
    logic [15:0]       stored_err;
    answer_t           expected_answers[$];
    int unsigned       failures;

    function new();
      bound_id      = '0;
      pending_ident = '0;
      stored_target = '0;
      high_seq      = '0;
      stored_uid    = '0;
      stored_dig    = '0;
      stored_err    = '0;
      failures      = 0;
    endfunction

    static function logic ident_valid(logic [63:0] v);
      return (v >= 64'd1) && (v <= IdentTop);
    endfunction

    // predict the answer to an accepted request and update the mirror
    function void note_request(request_t r);
      answer_t a;
      logic    valid;
      logic    same;
      a.ok    = 1'b0;
      a.bstat = BIND_BOUND;
      a.outc  = OUT_ACCEPTED;
      a.err   = '0;
      a.boot  = '0;
      a.seq   = '0;
      a.run   = 1'b0;
      case (r.mode)
        MODE_PROBE: begin
          if (ident_valid(r.id)) begin
            a.ok = 1'b1;
            if (bound_id == '0) pending_ident = r.id[IdentW-1:0];
          end
        end
        MODE_BIND: begin
          if (ident_valid(r.id) && ident_valid(r.prop)) begin
            a.ok = 1'b1;
            if (bound_id != '0) begin
              a.bstat = BIND_ALREADY;
            end else if (64'(pending_ident) != r.id) begin
              a.bstat = BIND_MISMATCH;
            end else begin
              bound_id      = r.prop[IdentW-1:0];
              pending_ident = '0;
            end
          end
        end
        default: begin
          valid = ident_valid(r.id) && (r.seq != '0) && (r.uid != '0);
          if (r.mode == MODE_RECEIVE && r.err > MaxErrorCodeDef) valid = 1'b0;
          if (valid) begin
            a.ok = 1'b1;
            if (64'(bound_id) != r.id) begin
              a.outc = OUT_BOOT_MIS;
            end else if (r.seq == high_seq) begin
              same = (64'(stored_target) == r.id) && (r.uid == stored_uid)
                  && (r.dig == stored_dig);
              if (same) begin
                a.err  = stored_err;
                a.outc = (stored_err == '0) ? OUT_ACCEPTED : OUT_REJECTED;
              end else begin
                a.outc = OUT_CONFLICT;
              end
            end else if (r.seq < high_seq) begin
              a.outc = OUT_OLD;
            end else if (r.mode == MODE_QUERY) begin
              a.outc = OUT_NOT_SEEN;
            end else begin
              high_seq      = r.seq;
              stored_target = r.id[IdentW-1:0];
              stored_uid    = r.uid;
              stored_dig    = r.dig;
              stored_err    = r.err;
              a.err         = r.err;
              a.outc        = (r.err == '0) ? OUT_ACCEPTED : OUT_REJECTED;
              a.run         = (r.err == '0);
            end
          end
        end
      endcase
      if (a.ok) begin
        a.boot = bound_id;
        a.seq  = high_seq;
      end
      expected_answers.push_back(a);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s expected %0h got %0h", name, want, got);
        failures++;
      end
    endfunction

    // match one answer against the oldest prediction
    function void check_answer(answer_t got);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $error("answer arrived with no request outstanding");
        failures++;
        return;
      end
      want = expected_answers.pop_front();
      compare_field("request_ok", 64'(want.ok), 64'(got.ok));
      compare_field("bind_status", 64'(want.bstat), 64'(got.bstat));
      compare_field("outcome", 64'(want.outc), 64'(got.outc));
      compare_field("error_out", 64'(want.err), 64'(got.err));
      compare_field("bound_boot", 64'(want.boot), 64'(got.boot));
      compare_field("top_sequence", 64'(want.seq), 64'(got.seq));
      compare_field("run_once", 64'(want.run), 64'(got.run));
    endfunction
  endclass

  // clock, reset and channel signals
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;

  // the request on the input channel; the payload ports follow it
  request_t drive_req;

  logic              request_ok_o;
  logic [1:0]        bind_status_o;
  logic [2:0]        outcome_o;
  logic [ErrW-1:0]   error_out_o;
  logic [IdentW-1:0] bound_boot_o;
  logic [SeqW-1:0]   top_sequence_o;
  logic              run_once_o;

  guard_scoreboard sb;
  int unsigned     requests_taken = 0;
  int              burst_left = 1;
  int              stall_left = 0;
  int unsigned     stall_style = 0;

  always #5 clk_i = ~clk_i;

  boot_bound_command_replay_guard_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .mode_i               (drive_req.mode),
    .probe_or_target_id_i (drive_req.id),
    .proposed_boot_i      (drive_req.prop),
    .seq_number_i         (drive_req.seq),
    .uid_low_i            (drive_req.uid[0]),
    .uid_high_i           (drive_req.uid[1]),
    .digest_w0_i          (drive_req.dig[0]),
    .digest_w1_i          (drive_req.dig[1]),
    .digest_w2_i          (drive_req.dig[2]),
    .digest_w3_i          (drive_req.dig[3]),
    .app_error_i          (drive_req.err),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .request_ok_o         (request_ok_o),
    .bind_status_o        (bind_status_o),
    .outcome_o            (outcome_o),
    .error_out_o          (error_out_o),
    .bound_boot_o         (bound_boot_o),
    .top_sequence_o       (top_sequence_o),
    .run_once_o           (run_once_o)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random identity in the valid range
  function automatic logic [63:0] rand_ident();
    logic [63:0] v;
    v = rand64();
    v[63:IdentW] = '0;
    if (v == '0) v = 64'd1;
    return v;
  endfunction

  function automatic request_t build_request(mode_e m, logic [63:0] id, logic [63:0] prop,
                                             logic [31:0] seq, logic [127:0] uid,
                                             logic [255:0] dig, logic [15:0] err);
    request_t r;
    r.mode = m;
    r.id   = id;
    r.prop = prop;
    r.seq  = seq;
    r.uid  = uid;
    r.dig  = dig;
    r.err  = err;
    return r;
  endfunction

  // random request shaped by the current guard state: mostly fresh commands
  // and exact repeats, then queries, stale commands, probe/bind and noise
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned w;
    logic [32:0] next;
    logic [63:0] flip;
    pick = $urandom_range(0, 99);
    r = build_request(MODE_RECEIVE, 64'(sb.bound_id), rand64(), '0,
                      {rand64(), rand64()}, {rand64(), rand64(), rand64(), rand64()}, '0);
    if (pick < 45) begin
      // fresh command, small steps with the odd large jump
      next = 33'(sb.high_seq) + (($urandom_range(0, 9) == 0) ?
             33'($urandom_range(1, 1 << 20)) : 33'($urandom_range(1, 8)));
      r.seq = next[32] ? sb.high_seq : next[31:0];
      if ($urandom_range(0, 19) == 0) r.id = rand_ident();
      w = $urandom_range(0, 19);
      if (w < 14) r.err = '0;
      else if (w < 19) r.err = 16'($urandom_range(1, MaxErrorCodeDef));
      else r.err = 16'($urandom_range(MaxErrorCodeDef + 1, 65535));
    end else if (pick < 65) begin
      // repeat of the latest command, sometimes with one bit or the target changed
      r.mode = $urandom_range(0, 1) ? MODE_RECEIVE : MODE_QUERY;
      r.id   = 64'(sb.stored_target);
      r.seq  = sb.high_seq;
      r.uid  = sb.stored_uid;
      r.dig  = sb.stored_dig;
      r.err  = sb.stored_err;
      if ($urandom_range(0, 9) < 3) begin
        flip = 64'd1 << $urandom_range(0, 63);
        w = $urandom_range(0, 6);
        if (w < 2) r.uid[w] ^= flip;
        else if (w < 6) r.dig[w-2] ^= flip;
        else r.id = rand_ident();
      end
    end else if (pick < 82) begin
      if (pick < 70 || sb.high_seq < 2) begin
        // query ahead of the latest command
        r.mode = MODE_QUERY;
        r.seq  = sb.high_seq + 32'd1 + 32'($urandom_range(0, 100));
        r.err  = 16'($urandom);
      end else begin
        // stale command
        r.mode = $urandom_range(0, 1) ? MODE_RECEIVE : MODE_QUERY;
        r.seq  = $urandom_range(1, sb.high_seq - 1);
      end
    end else if (pick < 88) begin
      r.mode = $urandom_range(0, 1) ? MODE_PROBE : MODE_BIND;
      r.id   = ($urandom_range(0, 3) == 0) ? rand64() : rand_ident();
      r.prop = ($urandom_range(0, 3) == 0) ? rand64() : rand_ident();
    end else begin
      // noise over mode, id, sequence, error code and uid
      r.mode = mode_e'($urandom_range(0, 3));
      r.id   = $urandom_range(0, 1) ? rand64() : rand_ident();
      r.seq  = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      r.err  = 16'($urandom);
      w = $urandom_range(0, 7);
      if (w == 0) r.uid = '0;
      else if (w == 1) r.uid[0] = '0;
    end
    return r;
  endfunction

  // put one request on the channel at a falling edge and hold it until taken,
  // then possibly leave a gap before the next burst
  task automatic send_request(request_t r);
    int unsigned target;
    drive_req  <= r;
    in_valid_i <= 1'b1;
    target = requests_taken + 1;
    while (requests_taken != target) @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  // receiver: four styles of stalling, picked at random
  always @(negedge clk_i) begin
    if (stall_left <= 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(4, 60);
    end
    stall_left--;
    case (stall_style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 7) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(drive_req);
        requests_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        got.ok    = request_ok_o;
        got.bstat = bind_status_o;
        got.outc  = outcome_o;
        got.err   = error_out_o;
        got.boot  = bound_boot_o;
        got.seq   = top_sequence_o;
        got.run   = run_once_o;
        sb.check_answer(got);
      end
    end
  end

  // main sequence
  initial begin
    logic [127:0] uid_a;
    logic [255:0] dig_a;
    logic [63:0]  bound;
    drive_req = build_request(MODE_PROBE, '0, '0, '0, '0, '0, '0);
    sb = new();
    uid_a = {rand64(), rand64()};
    dig_a = {rand64(), rand64(), rand64(), rand64()};
    bound = IdentTop;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // probes with identities out of range on both sides
    send_request(build_request(MODE_PROBE, '0, '0, 32'd1, uid_a, dig_a, '0));
    send_request(build_request(MODE_PROBE, IdentTop + 64'd1, '0, 32'd1, uid_a, dig_a, '0));
    send_request(build_request(MODE_PROBE, '1, '1, '1, '1, '1, '1));
    // command while unbound
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, uid_a, dig_a, '0));
    // bind with no pending probe, then probes overwriting each other
    send_request(build_request(MODE_BIND, 64'd5, bound, '0, '0, '0, '0));
    send_request(build_request(MODE_PROBE, 64'd1, '0, '0, '0, '0, '0));
    send_request(build_request(MODE_PROBE, 64'd77, '0, '0, '0, '0, '0));
    send_request(build_request(MODE_BIND, 64'd1, bound, '0, '0, '0, '0));
    // bind with proposed identity out of range
    send_request(build_request(MODE_BIND, 64'd77, '0, '0, '0, '0, '0));
    send_request(build_request(MODE_BIND, 64'd77, IdentTop + 64'd1, '0, '0, '0, '0));
    // good bind, then a second bind and a probe once bound
    send_request(build_request(MODE_BIND, 64'd77, bound, '0, '0, '0, '0));
    send_request(build_request(MODE_BIND, 64'd77, 64'd9, '0, '0, '0, '0));
    send_request(build_request(MODE_PROBE, 64'd3, '0, '0, '0, '0, '0));
    // malformed and mistargeted commands
    send_request(build_request(MODE_RECEIVE, 64'd1, '0, 32'd1, uid_a, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, '0, uid_a, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, '0, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, uid_a, dig_a, 16'd256));
    // a query ignores the error code
    send_request(build_request(MODE_QUERY, bound, '0, 32'd1, uid_a, dig_a, 16'hffff));
    // new command, exact repeat, then conflicting repeats
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, uid_a, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, uid_a, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd1, uid_a, ~dig_a, '0));
    send_request(build_request(MODE_QUERY, bound, '0, 32'd1, ~uid_a, dig_a, '0));
    // command with the largest error code, its repeat, a stale query
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd2, uid_a, dig_a,
                               16'(MaxErrorCodeDef)));
    send_request(build_request(MODE_QUERY, bound, '0, 32'd2, uid_a, dig_a, '0));
    send_request(build_request(MODE_QUERY, bound, '0, 32'd1, uid_a, dig_a, '0));
    // uid with only its high word set
    send_request(build_request(MODE_RECEIVE, bound, '0, 32'd3, {64'd1, 64'd0}, '0, '0));

    repeat (RandomCount) send_request(random_request());

    // top of the sequence range, its repeat and a stale command after it
    send_request(build_request(MODE_RECEIVE, bound, '0, '1, uid_a, dig_a, '0));
    send_request(build_request(MODE_RECEIVE, bound, '0, '1, uid_a, dig_a, '0));
    send_request(build_request(MODE_QUERY, bound, '0, 32'd1, uid_a, dig_a, '0));
    in_valid_i <= 1'b0;

    // drain, then allow for any stray answer
    while (sb.expected_answers.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
